// ----- hw/rtl/lsa_pkg.sv -----
`timescale 1ns / 1ps

package lsa_pkg;

   // request kinds carried in req_tuser
   localparam logic REQ_BEGIN = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // result status carried in rsp_tuser
   localparam logic [1:0] STATUS_PLACED    = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_NO_PAGE   = 2'd2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int POS_W      = 7;

   typedef enum logic [6:0] {
      FSM_CLEAR  = 7'b0000001,
      FSM_IDLE   = 7'b0000010,
      FSM_SUFFIX = 7'b0000100,
      FSM_SCAN   = 7'b0001000,
      FSM_DECIDE = 7'b0010000,
      FSM_UPDATE = 7'b0100000,
      FSM_FINISH = 7'b1000000
   } fsm_type;

   // result word: pos_s, pos_t, page_index, page_advanced from bit 0 up
   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [POS_W-1:0] pos_s,
      input logic [POS_W-1:0] pos_t,
      input logic [POS_W-1:0] page_index,
      input logic             page_advanced
   );
      pack_rsp = {2'b00, page_advanced, page_index, pos_t, pos_s};
   endfunction

endpackage

// ----- hw/rtl/lightmap_skyline_allocator_top.sv -----
`timescale 1ns / 1ps

// channel   direction  tdata (from bit 0)                          tuser
// req_      in         block_width[7:0], block_height[15:8]        req_type
// rsp_      out        pos_s[6:0], pos_t[13:7], page_index[20:14],  status[1:0]
//                      page_advanced[21], zero[23:22]
//
// for an allocate, a right-to-left pass over the skyline memory builds block suffix
// maxima, a left-to-right pass forms window maxima, then the covered columns are written
// one per cycle. closing a page swaps those writes for a clear sweep of every column.
// every pass is bound by the one read port of the skyline memory. after reset a clearing
// pass runs with req_tready low. the result sits in an output register, so a stalled
// result does not block the next request transfer.
module lightmap_skyline_allocator_top #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 128,
   parameter int PAGES   = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lsa_pkg::REQ_DATA_W-1:0]   req_tdata,  // block_width, block_height
   input  logic                             req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // pos_s, pos_t, page_index,
                                                        // page_advanced
   output logic [1:0]                       rsp_tuser   // status
);

   localparam int AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int HW  = $clog2(ROWS + 1);
   localparam int SW  = HW + 1;
   localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int PW1 = PW + 1;
   localparam int XW  = ((AW + 1 > 8) ? AW + 1 : 8) + 1;

   lsa_pkg::fsm_type state_ff, state_in;

   logic [AW-1:0] idx_ff, idx_in;
   logic          rd_on_ff, rd_on_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff, s1_last_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic [7:0]    r_ff, r_in;
   logic [HW-1:0] run_ff, run_in;
   logic [HW-1:0] best_ff, best_in;
   logic [AW-1:0] col_ff, col_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [HW-1:0] wval_ff, wval_in;
   logic [7:0]    bw_ff, bw_in;
   logic [7:0]    bh_ff, bh_in;
   logic [PW-1:0] page_ff, page_in;
   logic          started_ff, started_in;
   logic          clr_resp_ff, clr_resp_in;
   logic          clr_place_ff, clr_place_in;

   logic [lsa_pkg::RSP_DATA_W-1:0] res_data_ff, res_data_in;
   logic [1:0]                     res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lsa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;

   // skyline heights and per-block suffix maxima
   logic [HW-1:0] hmem [COLUMNS];
   logic [HW-1:0] smem [COLUMNS];
   logic [HW-1:0] hmem_q_ff;
   logic [HW-1:0] smem_q_ff;
   logic          hmem_we;
   logic [HW-1:0] hmem_wdata;
   logic          smem_we;
   logic [AW-1:0] smem_raddr;

   logic [HW-1:0] step_max;
   logic [HW-1:0] suf;
   logic          pre_reset;
   logic [HW-1:0] pre;
   logic [HW-1:0] wmax;
   logic [XW-1:0] e_ext;
   logic          win_ok;
   logic [AW-1:0] win_start;
   logic [HW-1:0] clear_val;
   logic [SW-1:0] fit_sum;
   logic          fits;
   logic [PW1-1:0] page_next;
   logic          no_page;
   logic          size_bad;

   assign req_tready = (state_ff == lsa_pkg::FSM_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign step_max  = (hmem_q_ff > run_ff) ? hmem_q_ff : run_ff;
   assign suf       = (r_ff == 8'd0) ? hmem_q_ff : step_max;
   assign pre_reset = (s1_addr_ff == '0) || (r_ff == bw_ff - 8'd1);
   assign pre       = pre_reset ? hmem_q_ff : step_max;
   assign wmax      = (smem_q_ff > pre) ? smem_q_ff : pre;
   assign e_ext     = XW'(s1_addr_ff) + XW'(1);
   assign win_ok    = (e_ext >= XW'(bw_ff));
   assign win_start = AW'(e_ext - XW'(bw_ff));
   assign smem_raddr = AW'(XW'(idx_ff) + XW'(1) - XW'(bw_ff));

   // on a page close the sweep also lays the block at the left edge of the fresh page
   assign clear_val = (clr_place_ff && (XW'(idx_ff) < XW'(bw_ff))) ? HW'(bh_ff) : '0;

   assign fit_sum   = SW'(best_ff) + SW'(bh_ff);
   assign fits      = (fit_sum <= SW'(ROWS));
   assign page_next = PW1'(page_ff) + PW1'(1);
   assign no_page   = (page_next >= PW1'(PAGES));
   assign size_bad  = (req_tdata[7:0] == 8'd0) || (req_tdata[15:8] == 8'd0)
                   || (int'(req_tdata[7:0]) > COLUMNS) || (int'(req_tdata[15:8]) > ROWS);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rd_on_in      = rd_on_ff;
      s1_valid_in   = 1'b0;
      s1_last_in    = 1'b0;
      s1_addr_in    = idx_ff;
      r_in          = r_ff;
      run_in        = run_ff;
      best_in       = best_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      wval_in       = wval_ff;
      bw_in         = bw_ff;
      bh_in         = bh_ff;
      page_in       = page_ff;
      started_in    = started_ff;
      clr_resp_in   = clr_resp_ff;
      clr_place_in  = clr_place_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      hmem_we       = 1'b0;
      hmem_wdata    = wval_ff;
      smem_we       = 1'b0;

      unique case (state_ff)
         lsa_pkg::FSM_CLEAR: begin
            hmem_we    = 1'b1;
            hmem_wdata = clear_val;
            if (int'(idx_ff) == COLUMNS - 1) begin
               idx_in   = '0;
               state_in = clr_resp_ff ? lsa_pkg::FSM_FINISH : lsa_pkg::FSM_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         lsa_pkg::FSM_IDLE: begin
            if (req_tvalid) begin
               bw_in = req_tdata[7:0];
               bh_in = req_tdata[15:8];
               if (req_tuser == lsa_pkg::REQ_BEGIN) begin
                  page_in       = '0;
                  started_in    = 1'b0;
                  clr_resp_in   = 1'b1;
                  clr_place_in  = 1'b0;
                  res_data_in   = '0;
                  res_status_in = lsa_pkg::STATUS_PLACED;
                  idx_in        = '0;
                  state_in      = lsa_pkg::FSM_CLEAR;
               end else if (size_bad) begin
                  res_data_in   = lsa_pkg::pack_rsp('0, '0, 7'(page_ff), 1'b0);
                  res_status_in = lsa_pkg::STATUS_TOO_LARGE;
                  state_in      = lsa_pkg::FSM_FINISH;
               end else begin
                  idx_in   = AW'(COLUMNS - 1);
                  rd_on_in = 1'b1;
                  r_in     = 8'd0;
                  state_in = lsa_pkg::FSM_SUFFIX;
               end
            end
         end
         lsa_pkg::FSM_SUFFIX: begin
            // right to left, suffix max restarts at each block's right end
            if (rd_on_ff) begin
               s1_valid_in = 1'b1;
               s1_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  rd_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end
            if (s1_valid_ff) begin
               smem_we = 1'b1;
               run_in  = suf;
               if (s1_last_ff) begin
                  // r keeps the phase of column 0 for the prefix pass
                  idx_in   = '0;
                  rd_on_in = 1'b1;
                  best_in  = HW'(ROWS);
                  col_in   = '0;
                  state_in = lsa_pkg::FSM_SCAN;
               end else begin
                  r_in = (r_ff == bw_ff - 8'd1) ? 8'd0 : r_ff + 8'd1;
               end
            end
         end
         lsa_pkg::FSM_SCAN: begin
            if (rd_on_ff) begin
               s1_valid_in = 1'b1;
               s1_last_in  = (int'(idx_ff) == COLUMNS - 1);
               if (int'(idx_ff) == COLUMNS - 1) begin
                  rd_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
            if (s1_valid_ff) begin
               run_in = pre;
               r_in   = (r_ff == 8'd0) ? bw_ff - 8'd1 : r_ff - 8'd1;
               // strictly lower keeps the leftmost of equal windows
               if (win_ok && (wmax < best_ff)) begin
                  best_in = wmax;
                  col_in  = win_start;
               end
               if (s1_last_ff) begin
                  state_in = lsa_pkg::FSM_DECIDE;
               end
            end
         end
         lsa_pkg::FSM_DECIDE: begin
            priority if (fits) begin
               wval_in       = HW'(fit_sum);
               idx_in        = col_ff;
               cnt_in        = bw_ff;
               started_in    = 1'b1;
               res_data_in   = lsa_pkg::pack_rsp(7'(col_ff), 7'(best_ff), 7'(page_ff), 1'b0);
               res_status_in = lsa_pkg::STATUS_PLACED;
               state_in      = lsa_pkg::FSM_UPDATE;
            end else if (!started_ff) begin
               res_data_in   = lsa_pkg::pack_rsp('0, '0, 7'(page_ff), 1'b0);
               res_status_in = lsa_pkg::STATUS_TOO_LARGE;
               state_in      = lsa_pkg::FSM_FINISH;
            end else if (no_page) begin
               res_data_in   = lsa_pkg::pack_rsp('0, '0, 7'(page_ff), 1'b0);
               res_status_in = lsa_pkg::STATUS_NO_PAGE;
               state_in      = lsa_pkg::FSM_FINISH;
            end else begin
               page_in       = PW'(page_next);
               clr_resp_in   = 1'b1;
               clr_place_in  = 1'b1;
               idx_in        = '0;
               res_data_in   = lsa_pkg::pack_rsp('0, '0, 7'(page_next), 1'b1);
               res_status_in = lsa_pkg::STATUS_PLACED;
               state_in      = lsa_pkg::FSM_CLEAR;
            end
         end
         lsa_pkg::FSM_UPDATE: begin
            hmem_we = 1'b1;
            if (cnt_ff == 8'd1) begin
               state_in = lsa_pkg::FSM_FINISH;
            end else begin
               cnt_in = cnt_ff - 8'd1;
               idx_in = idx_ff + AW'(1);
            end
         end
         lsa_pkg::FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = lsa_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = lsa_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsa_pkg::FSM_CLEAR;
         idx_ff       <= '0;
         rd_on_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         page_ff      <= '0;
         started_ff   <= 1'b0;
         clr_resp_ff  <= 1'b0;
         clr_place_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_on_ff     <= rd_on_in;
         s1_valid_ff  <= s1_valid_in;
         page_ff      <= page_in;
         started_ff   <= started_in;
         clr_resp_ff  <= clr_resp_in;
         clr_place_ff <= clr_place_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff    <= s1_last_in;
      s1_addr_ff    <= s1_addr_in;
      r_ff          <= r_in;
      run_ff        <= run_in;
      best_ff       <= best_in;
      col_ff        <= col_in;
      cnt_ff        <= cnt_in;
      wval_ff       <= wval_in;
      bw_ff         <= bw_in;
      bh_ff         <= bh_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (hmem_we) begin
         hmem[idx_ff] <= hmem_wdata;
      end
      hmem_q_ff <= hmem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[s1_addr_ff] <= suf;
      end
      smem_q_ff <= smem[smem_raddr];
   end

   a_page_range: assert property (@(posedge clock) disable iff (reset)
      int'(page_ff) < PAGES)
      else $error("page counter beyond page count");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsa_pkg::FSM_SCAN) |-> (int'(best_ff) <= ROWS))
      else $error("window height above page height");

   a_update_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsa_pkg::FSM_UPDATE) |-> (int'(idx_ff) + int'(cnt_ff) <= COLUMNS))
      else $error("column update runs past the right edge");

   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lsa_pkg::FSM_FINISH) && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_tvalid && (state_ff == lsa_pkg::FSM_IDLE)))
      else $error("result not loaded into output register");

endmodule
